// ===== hw/rtl/sensor_response_packet_deframer_assert.svh =====
// assertion macros shared by the deframer rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef SENSOR_RESPONSE_PACKET_DEFRAMER_ASSERT_SVH
`define SENSOR_RESPONSE_PACKET_DEFRAMER_ASSERT_SVH

// property checked on every clock edge outside reset
`define SRPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define SRPD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/srpd_pkg.sv =====
// types and constants for the reply frame deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package srpd_pkg;

  // input op codes
  localparam logic OP_ARM  = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // register indexes on the config port
  localparam logic [1:0] REG_DEVICE_ADDR = 2'd0;
  localparam logic [1:0] REG_START_CODE  = 2'd1;
  localparam logic [1:0] REG_END_TYPE    = 2'd2;
  localparam logic [1:0] REG_UPLOAD      = 2'd3;

  // register reset values
  localparam logic [31:0] DEVICE_ADDR_RST = 32'hFFFF_FFFF;
  localparam logic [15:0] START_CODE_RST  = 16'hEF01;
  localparam logic [7:0]  END_TYPE_RST    = 8'h08;

  // confirm code that marks the sensor as ready
  localparam logic [7:0] READY_CODE = 8'h55;

  typedef enum logic [2:0] {
    PS_IDLE    = 3'd0,
    PS_START   = 3'd1,
    PS_ADDR    = 3'd2,
    PS_TYPE    = 3'd3,
    PS_LEN     = 3'd4,
    PS_BODY    = 3'd5,
    PS_SUM     = 3'd6,
    PS_DISCARD = 3'd7
  } parse_state_e;

  typedef enum logic [1:0] {
    KIND_RESP   = 2'd0,
    KIND_UPLOAD = 2'd1,
    KIND_DONE   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_PAYLOAD = 2'd1,
    STAT_BAD        = 2'd2
  } status_e;

  // configuration seen by the parser
  typedef struct packed {
    logic [31:0] device_address;
    logic [15:0] start_code;
    logic [7:0]  end_type;
    logic        upload_expected;
  } cfg_t;

  // one result word from the parser
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  data;
    status_e     status;
    logic [7:0]  confirm;
    logic        ready;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srpd_if.sv =====
// valid/ready stream interfaces for received bytes and results
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface srpd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_value;

  modport source (output valid, output op, output byte_value, input ready);
  modport sink (input valid, input op, input byte_value, output ready);
endinterface

interface srpd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic [7:0] confirm_code;
  logic       sensor_ready;
  logic       last;

  modport source (
    output valid, output out_kind, output out_byte, output status,
    output confirm_code, output sensor_ready, output last, input ready
  );
  modport sink (
    input valid, input out_kind, input out_byte, input status,
    input confirm_code, input sensor_ready, input last, output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/sensor_response_packet_deframer.sv =====
// Reply frame deframer for a fingerprint module serial link. Arm with op 0, then feed
// received bytes with op 1; response payload bytes, upload data bytes and one done word
// per reception come out on the result channel. One byte is taken every cycle: the parser
// registers its state per accepted byte and a one-deep output register holds the result, so
// the input stalls only while that register is full and not being taken. Configuration
// lives on the APB port (device address, start code, end type, upload flag at 0x0..0xC).
// depends on srpd_pkg, srpd_if, srpd_parser and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "sensor_response_packet_deframer_assert.svh"

module sensor_response_packet_deframer import srpd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  srpd_in_if.sink          in_i,
  srpd_out_if.source       out_o
);

  cfg_t  cfg_q;
  res_t  res;
  res_t  out_q;
  logic  out_valid_q;
  logic  in_ready;
  logic  step;
  logic  cfg_we;
  logic  done_out;
  logic  byte_out;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address  <= DEVICE_ADDR_RST;
      cfg_q.start_code      <= START_CODE_RST;
      cfg_q.end_type        <= END_TYPE_RST;
      cfg_q.upload_expected <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_DEVICE_ADDR: cfg_q.device_address  <= pwdata;
        REG_START_CODE:  cfg_q.start_code      <= pwdata[15:0];
        REG_END_TYPE:    cfg_q.end_type        <= pwdata[7:0];
        REG_UPLOAD:      cfg_q.upload_expected <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_DEVICE_ADDR: prdata = cfg_q.device_address;
      REG_START_CODE:  prdata = {16'h0000, cfg_q.start_code};
      REG_END_TYPE:    prdata = {24'h000000, cfg_q.end_type};
      REG_UPLOAD:      prdata = {31'h0, cfg_q.upload_expected};
      default:         prdata = 32'h0;
    endcase
  end

  // accept while the output register is empty or draining
  assign in_ready   = !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign step       = in_i.valid && in_ready;

  srpd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .op_i   (in_i.op),
    .byte_i (in_i.byte_value),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_kind     = out_q.kind;
  assign out_o.out_byte     = out_q.data;
  assign out_o.status       = out_q.status;
  assign out_o.confirm_code = out_q.confirm;
  assign out_o.sensor_ready = out_q.ready;
  assign out_o.last         = out_q.last;

  // terms for the checks below
  assign done_out = out_q.kind == KIND_DONE;
  assign byte_out = out_valid_q && !out_q.last;

  // empty output register never stalls the input
  `SRPD_ASSERT(a_ready_when_empty, !out_valid_q |-> in_ready, "input stalled with empty output")
  // last marks exactly the done word
  `SRPD_ASSERT(a_last_is_done, out_valid_q |-> (out_q.last == done_out), "last flag disagrees")
  // byte words carry ok status
  `SRPD_ASSERT(a_byte_status, byte_out |-> out_q.status == STAT_OK, "byte word not ok")

endmodule

`default_nettype wire

// ===== hw/rtl/srpd_parser.sv =====
// frame parser state machine: one byte per step, result word combinational
// depends on srpd_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "sensor_response_packet_deframer_assert.svh"

module srpd_parser import srpd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       op_i,
  input  wire logic [7:0] byte_i,
  input  wire cfg_t       cfg_i,
  output res_t            res_o
);

  parse_state_e state_q, state_d;
  logic [2:0]   idx_q, idx_d;
  logic [31:0]  shift_q, shift_d;
  logic [7:0]   type_q, type_d;
  logic [15:0]  left_q, left_d;
  logic         upload_q, upload_d;
  logic [7:0]   confirm_q, confirm_d;
  logic         have_q, have_d;
  logic         ready_q, ready_d;
  logic [15:0]  len;
  logic         bad_word;
  logic         quiet_byte;

  // done word, carrying confirm and ready as they stand
  function automatic res_t done_word(status_e s, logic [7:0] c, logic r);
    res_t w;
    w.valid   = 1'b1;
    w.kind    = KIND_DONE;
    w.data    = 8'h00;
    w.status  = s;
    w.confirm = c;
    w.ready   = r;
    w.last    = 1'b1;
    return w;
  endfunction

  // next state and result for the current word
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    shift_d   = shift_q;
    type_d    = type_q;
    left_d    = left_q;
    upload_d  = upload_q;
    confirm_d = confirm_q;
    have_d    = have_q;
    ready_d   = ready_q;
    len       = 16'h0000;
    res_o     = '0;
    if (op_i == OP_ARM) begin
      state_d   = PS_START;
      idx_d     = 3'd0;
      shift_d   = 32'h0;
      type_d    = 8'h00;
      left_d    = 16'h0000;
      upload_d  = 1'b0;
      confirm_d = 8'h00;
      have_d    = 1'b0;
    end else begin
      case (state_q)
        PS_START: begin
          shift_d = {shift_q[23:0], byte_i};
          idx_d   = idx_q + 3'd1;
          if (idx_d >= 3'd2) begin
            if (shift_d[15:0] != cfg_i.start_code) begin
              res_o   = done_word(STAT_BAD, confirm_q, ready_q);
              state_d = PS_DISCARD;
            end else begin
              state_d = PS_ADDR;
              idx_d   = 3'd0;
              shift_d = 32'h0;
            end
          end
        end
        PS_ADDR: begin
          shift_d = {shift_q[23:0], byte_i};
          idx_d   = idx_q + 3'd1;
          if (idx_d >= 3'd4) begin
            // data packets skip the address check
            if (!upload_q && shift_d != cfg_i.device_address) begin
              res_o   = done_word(STAT_BAD, confirm_q, ready_q);
              state_d = PS_DISCARD;
            end else begin
              state_d = PS_TYPE;
              idx_d   = 3'd0;
            end
          end
        end
        PS_TYPE: begin
          type_d  = byte_i;
          state_d = PS_LEN;
          idx_d   = 3'd0;
          shift_d = 32'h0;
        end
        PS_LEN: begin
          shift_d = {shift_q[23:0], byte_i};
          idx_d   = idx_q + 3'd1;
          if (idx_d >= 3'd2) begin
            len     = shift_d[15:0];
            left_d  = (len > 16'd2) ? len - 16'd2 : 16'd0;
            idx_d   = 3'd0;
            state_d = (left_d == 16'd0) ? PS_SUM : PS_BODY;
          end
        end
        PS_BODY: begin
          left_d = left_q - 16'd1;
          if (left_d == 16'd0) begin
            state_d = PS_SUM;
            idx_d   = 3'd0;
          end
          res_o.valid  = 1'b1;
          res_o.data   = byte_i;
          res_o.status = STAT_OK;
          res_o.last   = 1'b0;
          if (upload_q) begin
            res_o.kind = KIND_UPLOAD;
          end else begin
            // first response byte is the confirm code
            if (!have_q) begin
              have_d    = 1'b1;
              confirm_d = byte_i;
              if (byte_i == READY_CODE) begin
                ready_d = 1'b1;
              end
            end
            res_o.kind = KIND_RESP;
          end
          res_o.confirm = confirm_d;
          res_o.ready   = ready_d;
        end
        PS_SUM: begin
          // checksum bytes are counted, not checked
          idx_d = idx_q + 3'd1;
          if (idx_d >= 3'd2) begin
            idx_d   = 3'd0;
            shift_d = 32'h0;
            if (type_q != cfg_i.end_type && (upload_q || cfg_i.upload_expected)) begin
              upload_d = 1'b1;
              state_d  = PS_START;
            end else begin
              res_o   = done_word(have_q ? STAT_OK : STAT_NO_PAYLOAD, confirm_q, ready_q);
              state_d = PS_IDLE;
            end
          end
        end
        default: begin
          // idle and discard drop bytes
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= PS_IDLE;
      idx_q     <= 3'd0;
      shift_q   <= 32'h0;
      type_q    <= 8'h00;
      left_q    <= 16'h0000;
      upload_q  <= 1'b0;
      confirm_q <= 8'h00;
      have_q    <= 1'b0;
      ready_q   <= 1'b0;
    end else if (step_i) begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      shift_q   <= shift_d;
      type_q    <= type_d;
      left_q    <= left_d;
      upload_q  <= upload_d;
      confirm_q <= confirm_d;
      have_q    <= have_d;
      ready_q   <= ready_d;
    end
  end

  // terms for the checks below
  assign bad_word   = step_i && res_o.valid && res_o.status == STAT_BAD;
  assign quiet_byte = (state_q == PS_IDLE || state_q == PS_DISCARD) && op_i == OP_BYTE;

  // sensor ready stays set across rearming
  `SRPD_ASSERT(a_ready_sticky, ready_q |=> ready_q, "sensor ready flag cleared")
  // a bad packet always leads into discard
  `SRPD_ASSERT(a_bad_discards, bad_word |=> state_q == PS_DISCARD, "bad packet kept parsing")
  // no word leaves while idle or discarding
  `SRPD_ASSERT_NEVER(a_quiet_idle, quiet_byte && res_o.valid, "result produced while idle")

endmodule

`default_nettype wire
